### hdl/aef_pkg.sv
`default_nettype none

package aef_pkg;

    localparam int ALPHA_BITS    = 17;
    localparam int SPAN_BITS     = 16;
    localparam int Q16_SHIFT     = 16;
    localparam int DIV_STEPS     = 16;
    localparam int CNT_BITS      = 4;
    localparam int CHUNK_BITS    = 16;
    localparam int MUL_BITS      = 18;
    localparam int PROD_BITS     = 2 * MUL_BITS;
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    localparam logic [ALPHA_BITS-1:0] Q16_ONE        = 17'h10000;
    localparam logic [ALPHA_BITS-1:0] RST_ALPHA_LOW  = 17'd6554;
    localparam logic [ALPHA_BITS-1:0] RST_ALPHA_HIGH = 17'd65536;
    localparam logic [SPAN_BITS-1:0]  RST_ERROR_SPAN = 16'd100;

    typedef enum logic [1:0] {
        REG_ALPHA_LOW  = 2'd0,
        REG_ALPHA_HIGH = 2'd1,
        REG_ERROR_SPAN = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [ALPHA_BITS-1:0] alpha_low;
        logic [ALPHA_BITS-1:0] alpha_high;
        logic [SPAN_BITS-1:0]  error_span;
    } cfg_t;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_DIFF  = 9'b000000010,
        ST_CHECK = 9'b000000100,
        ST_DIV   = 9'b000001000,
        ST_AMUL  = 9'b000010000,
        ST_AADD  = 9'b000100000,
        ST_SMUL  = 9'b001000000,
        ST_SACC  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    typedef struct packed {
        logic capture;
        logic diff_load;
        logic check;
        logic div_step;
        logic alpha_mul;
        logic alpha_add;
        logic step_mul;
        logic step_acc;
        logic first_chunk;
        logic finish;
        logic copy;
    } cmd_t;

    typedef struct packed {
        logic saturate;
    } status_t;

endpackage

`default_nettype wire

### hdl/aef_sample_if.sv
`default_nettype none

interface aef_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

### hdl/aef_smoothed_if.sv
`default_nettype none

interface aef_smoothed_if #(
    parameter int VALUE_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] smoothed;

    modport source (output valid, output smoothed, input ready);
    modport sink (input valid, input smoothed, output ready);
endinterface

`default_nettype wire

### hdl/adaptive_ema_filter.sv
// The first sample after reset is copied straight to the output. Later samples skip the
// divider when the error reaches the span (or the span is zero) and run it otherwise,
// then do the alpha*diff multiply in CHUNKS = ceil((SAMPLE_BITS+FRAC_BITS+1)/16) chunks.
// The 16-step serial divider, chunked alpha*diff multiply and output stalls set the rate;
// a new sample is taken in the cycle after the result is loaded into the output register.
// Reset is asynchronous, active low: value cleared, next sample copied, registers at defaults.
`default_nettype none

module adaptive_ema_filter #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    aef_sample_if.sink                             in_ch,
    aef_smoothed_if.source                         out_ch,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [aef_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic [aef_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic      [aef_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                   pready
);

    localparam int DIFF_BITS = SAMPLE_BITS + FRAC_BITS + 1;
    localparam int CHUNKS    = (DIFF_BITS + aef_pkg::CHUNK_BITS - 1) / aef_pkg::CHUNK_BITS;

    aef_pkg::cfg_t    cfg;
    aef_pkg::cmd_t    cmd;
    aef_pkg::status_t status;

    aef_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    aef_ctrl #(
        .CHUNKS (CHUNKS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .status    (status),
        .cmd       (cmd)
    );

    aef_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .sample   (in_ch.sample),
        .status   (status),
        .smoothed (out_ch.smoothed)
    );

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("sample beat accepted while busy");

    a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> in_ch.ready)
        else $error("result beat without return to idle");

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.diff_load, cmd.check, cmd.div_step, cmd.alpha_mul,
                  cmd.alpha_add, cmd.step_mul, cmd.step_acc, cmd.finish}))
        else $error("overlapping datapath commands");

    a_finish_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_ch.valid)
        else $error("finished item not presented");

endmodule

`default_nettype wire

### hdl/aef_regs.sv
`default_nettype none

module aef_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [aef_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [aef_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic      [aef_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                    pready,
    output aef_pkg::cfg_t                           cfg
);

    aef_pkg::reg_idx_t idx;
    aef_pkg::cfg_t     cfg_reg;
    aef_pkg::cfg_t     cfg_next;
    logic              wr_en;

    assign idx    = aef_pkg::reg_idx_t'(paddr[aef_pkg::APB_ADDR_BITS-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                aef_pkg::REG_ALPHA_LOW:
                    cfg_next.alpha_low = pwdata[aef_pkg::ALPHA_BITS-1:0];
                aef_pkg::REG_ALPHA_HIGH:
                    cfg_next.alpha_high = pwdata[aef_pkg::ALPHA_BITS-1:0];
                aef_pkg::REG_ERROR_SPAN:
                    cfg_next.error_span = pwdata[aef_pkg::SPAN_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            aef_pkg::REG_ALPHA_LOW:
                prdata = aef_pkg::APB_DATA_BITS'(cfg_reg.alpha_low);
            aef_pkg::REG_ALPHA_HIGH:
                prdata = aef_pkg::APB_DATA_BITS'(cfg_reg.alpha_high);
            aef_pkg::REG_ERROR_SPAN:
                prdata = aef_pkg::APB_DATA_BITS'(cfg_reg.error_span);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha_low  <= aef_pkg::RST_ALPHA_LOW;
            cfg_reg.alpha_high <= aef_pkg::RST_ALPHA_HIGH;
            cfg_reg.error_span <= aef_pkg::RST_ERROR_SPAN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### hdl/aef_ctrl.sv
`default_nettype none

module aef_ctrl #(
    parameter int CHUNKS = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             out_ready,
    output logic                  out_valid,
    input  wire aef_pkg::status_t status,
    output aef_pkg::cmd_t         cmd
);

    aef_pkg::state_t               state_reg;
    aef_pkg::state_t               state_next;
    logic [aef_pkg::CNT_BITS-1:0]  cnt_reg;
    logic [aef_pkg::CNT_BITS-1:0]  cnt_next;
    logic                          first_pending_reg;
    logic                          first_pending_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign in_ready  = (state_reg == aef_pkg::ST_IDLE);

    always_comb
    begin
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        first_pending_next = first_pending_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        cmd                = '0;
        case (state_reg)
            aef_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = aef_pkg::ST_DIFF;
                end
            end
            aef_pkg::ST_DIFF:
            begin
                cmd.diff_load = 1'b1;
                state_next    = first_pending_reg ? aef_pkg::ST_DONE : aef_pkg::ST_CHECK;
            end
            aef_pkg::ST_CHECK:
            begin
                cmd.check  = 1'b1;
                cnt_next   = '0;
                state_next = status.saturate ? aef_pkg::ST_AMUL : aef_pkg::ST_DIV;
            end
            aef_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == aef_pkg::CNT_BITS'(aef_pkg::DIV_STEPS - 1))
                begin
                    state_next = aef_pkg::ST_AMUL;
                end
            end
            aef_pkg::ST_AMUL:
            begin
                cmd.alpha_mul = 1'b1;
                state_next    = aef_pkg::ST_AADD;
            end
            aef_pkg::ST_AADD:
            begin
                cmd.alpha_add = 1'b1;
                cnt_next      = '0;
                state_next    = aef_pkg::ST_SMUL;
            end
            aef_pkg::ST_SMUL:
            begin
                cmd.step_mul    = 1'b1;
                cmd.first_chunk = (cnt_reg == '0);
                state_next      = aef_pkg::ST_SACC;
            end
            aef_pkg::ST_SACC:
            begin
                cmd.step_acc    = 1'b1;
                cmd.first_chunk = (cnt_reg == '0);
                cnt_next        = cnt_reg + 1'b1;
                state_next      = (cnt_reg == aef_pkg::CNT_BITS'(CHUNKS - 1)) ?
                                  aef_pkg::ST_DONE : aef_pkg::ST_SMUL;
            end
            aef_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.finish         = 1'b1;
                    cmd.copy           = first_pending_reg;
                    first_pending_next = 1'b0;
                    out_valid_next     = 1'b1;
                    state_next         = aef_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = aef_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= aef_pkg::ST_IDLE;
            cnt_reg           <= '0;
            first_pending_reg <= 1'b1;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            cnt_reg           <= cnt_next;
            first_pending_reg <= first_pending_next;
            out_valid_reg     <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### hdl/aef_dp.sv
`default_nettype none

module aef_dp #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire aef_pkg::cfg_t                             cfg,
    input  wire aef_pkg::cmd_t                             cmd,
    input  wire logic signed [SAMPLE_BITS-1:0]             sample,
    output aef_pkg::status_t                               status,
    output logic signed      [SAMPLE_BITS+FRAC_BITS-1:0]   smoothed
);

    localparam int VALUE_BITS = SAMPLE_BITS + FRAC_BITS;
    localparam int DIFF_BITS  = VALUE_BITS + 1;
    localparam int CHUNKS     = (DIFF_BITS + aef_pkg::CHUNK_BITS - 1) / aef_pkg::CHUNK_BITS;
    localparam int EXT_BITS   = CHUNKS * aef_pkg::CHUNK_BITS;
    localparam int ACC_BITS   = EXT_BITS + aef_pkg::ALPHA_BITS;
    localparam int SPANQ_BITS = aef_pkg::SPAN_BITS + FRAC_BITS;
    localparam int REM_BITS   = SPANQ_BITS + 1;
    localparam int CMP_BITS   = DIFF_BITS + SPANQ_BITS;

    logic signed [VALUE_BITS-1:0]          target_reg;
    logic signed [VALUE_BITS-1:0]          running_reg;
    logic signed [VALUE_BITS-1:0]          smoothed_reg;
    logic signed [DIFF_BITS-1:0]           diff_reg;
    logic        [DIFF_BITS-1:0]           err_reg;
    logic        [REM_BITS-1:0]            rem_reg;
    logic        [aef_pkg::ALPHA_BITS-1:0] factor_reg;
    logic        [aef_pkg::ALPHA_BITS-1:0] alpha_reg;
    logic signed [aef_pkg::PROD_BITS-1:0]  prod_reg;
    logic signed [EXT_BITS-1:0]            chunk_reg;
    logic signed [ACC_BITS-1:0]            acc_reg;

    logic signed [VALUE_BITS-1:0]          target_next;
    logic signed [DIFF_BITS-1:0]           diff_next;
    logic        [DIFF_BITS-1:0]           err_next;
    logic        [SPANQ_BITS-1:0]          span_q;
    logic        [REM_BITS-1:0]            rem_shift;
    logic                                  rem_fits;
    logic        [aef_pkg::ALPHA_BITS-1:0] lo_a;
    logic        [aef_pkg::ALPHA_BITS-1:0] hi_a;
    logic signed [aef_pkg::MUL_BITS-1:0]   alpha_delta;
    logic        [aef_pkg::CHUNK_BITS-1:0] chunk_top;
    logic signed [aef_pkg::MUL_BITS-1:0]   mul_a;
    logic signed [aef_pkg::MUL_BITS-1:0]   mul_b;
    logic signed [aef_pkg::PROD_BITS-1:0]  mul_p;
    logic signed [aef_pkg::ALPHA_BITS+1:0] alpha_sum;
    logic signed [ACC_BITS-1:0]            acc_next;
    logic signed [VALUE_BITS-1:0]          step;
    logic signed [VALUE_BITS-1:0]          value_next;

    assign target_next = VALUE_BITS'(sample) <<< FRAC_BITS;
    assign diff_next   = DIFF_BITS'(target_reg) - DIFF_BITS'(running_reg);
    assign err_next    = diff_reg[DIFF_BITS-1] ? $unsigned(-diff_reg) : $unsigned(diff_reg);
    assign span_q      = SPANQ_BITS'(cfg.error_span) << FRAC_BITS;

    assign status.saturate = (cfg.error_span == '0) ||
                             (CMP_BITS'(err_reg) >= CMP_BITS'(span_q));

    // restoring divide, one quotient bit per cycle
    assign rem_shift = {rem_reg[REM_BITS-2:0], 1'b0};
    assign rem_fits  = (rem_shift >= REM_BITS'(span_q));

    assign lo_a = (cfg.alpha_low > aef_pkg::Q16_ONE) ? aef_pkg::Q16_ONE : cfg.alpha_low;
    assign hi_a = (cfg.alpha_high > aef_pkg::Q16_ONE) ? aef_pkg::Q16_ONE : cfg.alpha_high;
    assign alpha_delta = $signed({1'b0, hi_a}) - $signed({1'b0, lo_a});

    // shared multiplier: alpha blend, then alpha * diff one chunk at a time, top first
    assign chunk_top = chunk_reg[EXT_BITS-1 -: aef_pkg::CHUNK_BITS];

    always_comb
    begin
        if (cmd.alpha_mul)
        begin
            mul_a = alpha_delta;
            mul_b = $signed({1'b0, factor_reg});
        end
        else
        begin
            mul_a = $signed({1'b0, alpha_reg});
            if (cmd.first_chunk)
            begin
                mul_b = $signed({{2{chunk_top[aef_pkg::CHUNK_BITS-1]}}, chunk_top});
            end
            else
            begin
                mul_b = $signed({2'b00, chunk_top});
            end
        end
    end

    assign mul_p = mul_a * mul_b;

    assign alpha_sum = $signed({2'b00, lo_a}) +
                       (aef_pkg::ALPHA_BITS + 2)'(prod_reg >>> aef_pkg::Q16_SHIFT);

    assign acc_next = cmd.first_chunk ? ACC_BITS'(prod_reg) :
                      (acc_reg <<< aef_pkg::CHUNK_BITS) + ACC_BITS'(prod_reg);

    assign step       = acc_reg[VALUE_BITS+aef_pkg::Q16_SHIFT-1:aef_pkg::Q16_SHIFT];
    assign value_next = cmd.copy ? target_reg : running_reg + step;
    assign smoothed   = smoothed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= '0;
        end
        else if (cmd.finish)
        begin
            running_reg <= value_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            target_reg <= target_next;
        end
        if (cmd.diff_load)
        begin
            diff_reg <= diff_next;
        end
        if (cmd.diff_load)
        begin
            err_reg <= $unsigned(diff_next[DIFF_BITS-1] ? -diff_next : diff_next);
        end
        if (cmd.check)
        begin
            rem_reg    <= REM_BITS'(err_next);
            factor_reg <= status.saturate ? aef_pkg::Q16_ONE : '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg    <= rem_fits ? rem_shift - REM_BITS'(span_q) : rem_shift;
            factor_reg <= {factor_reg[aef_pkg::ALPHA_BITS-2:0], rem_fits};
        end
        if (cmd.alpha_mul || cmd.step_mul)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.alpha_add)
        begin
            alpha_reg <= alpha_sum[aef_pkg::ALPHA_BITS-1:0];
            chunk_reg <= EXT_BITS'(diff_reg);
        end
        else if (cmd.step_mul)
        begin
            chunk_reg <= chunk_reg <<< aef_pkg::CHUNK_BITS;
        end
        if (cmd.step_acc)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.finish)
        begin
            smoothed_reg <= value_next;
        end
    end

endmodule

`default_nettype wire
